/* src/pul_pkg.sv */
// ----------------------------------------------------------------------------
// pul_pkg: shared types and constants for the permutation unrank block
// Widths, the factorial table, the job record and the back-end states.
// ----------------------------------------------------------------------------
package pul_pkg;

    localparam int MAX_LEN   = 9;
    localparam int OUT_ELEMS = 9;
    localparam int RANK_W    = 19;
    localparam int FACT_W    = 29;   // holds 12!
    localparam int CFG_W     = 4;
    localparam int ELEM_W    = 4;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int CNT_W     = LEN_W;
    localparam int ARR_N     = (MAX_LEN > OUT_ELEMS) ? MAX_LEN : OUT_ELEMS;
    localparam int POS_W     = $clog2(ARR_N);
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    typedef logic [ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic [RANK_W-1:0] rest;   // rank minus one
        logic [LEN_W-1:0]  len;    // effective length
        logic              err;    // bad rank
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIGIT,
        BK_DONE
    } t_back_state;

    function automatic logic [FACT_W-1:0] fact(input logic [LEN_W-1:0] k);
        logic [FACT_W-1:0] f;
        case (k)
            0:       f = FACT_W'(1);
            1:       f = FACT_W'(1);
            2:       f = FACT_W'(2);
            3:       f = FACT_W'(6);
            4:       f = FACT_W'(24);
            5:       f = FACT_W'(120);
            6:       f = FACT_W'(720);
            7:       f = FACT_W'(5040);
            8:       f = FACT_W'(40320);
            9:       f = FACT_W'(362880);
            10:      f = FACT_W'(3628800);
            11:      f = FACT_W'(39916800);
            12:      f = FACT_W'(479001600);
            default: f = '0;
        endcase
        return f;
    endfunction

    // zero reads as one, oversize saturates
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] cfg);
        logic [LEN_W-1:0] n;
        if (cfg == '0) begin
            n = LEN_W'(1);
        end else if (int'(cfg) > MAX_LEN) begin
            n = LEN_W'(MAX_LEN);
        end else begin
            n = LEN_W'(cfg);
        end
        return n;
    endfunction

endpackage

/* src/permutation_unrank.sv */
// ----------------------------------------------------------------------------
// permutation_unrank: rank to permutation (inverse Cantor expansion)
// Turns a one-based lexicographic rank into the permutation of 1..n.
// ----------------------------------------------------------------------------
//
//  channel   handshake                   payload
//  -------   -------------------------   --------------------------------
//  input     push / full                 i_rank (19b)
//  result    pop / empty                 o_elem_1..o_elem_9, o_rank_error
//  config    i_cfg_valid / o_cfg_ready   i_cfg_data -> perm_length (4b)
//
//  Steps: the back end does each factorial subtraction as its own step and
//  then one pick step per position, in a shared compare-subtract loop; a
//  bad rank goes straight from idle to the done state.
//  Reset (synchronous, active low) empties the queue and result register and
//  sets perm_length to 9. The front keeps taking ranks into a two-entry queue
//  while the back works; full rises only when that queue is full. A result
//  waiting for pop stalls only the final transfer into the result register.
//
module permutation_unrank (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // rank input
    input  logic                        push,
    output logic                        full,
    input  logic [pul_pkg::RANK_W-1:0]  i_rank,
    // result output
    output logic                        empty,
    input  logic                        pop,
    output logic [pul_pkg::ELEM_W-1:0]  o_elem_1,
    output logic [pul_pkg::ELEM_W-1:0]  o_elem_2,
    output logic [pul_pkg::ELEM_W-1:0]  o_elem_3,
    output logic [pul_pkg::ELEM_W-1:0]  o_elem_4,
    output logic [pul_pkg::ELEM_W-1:0]  o_elem_5,
    output logic [pul_pkg::ELEM_W-1:0]  o_elem_6,
    output logic [pul_pkg::ELEM_W-1:0]  o_elem_7,
    output logic [pul_pkg::ELEM_W-1:0]  o_elem_8,
    output logic [pul_pkg::ELEM_W-1:0]  o_elem_9,
    output logic                        o_rank_error,
    // perm_length write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pul_pkg::CFG_W-1:0]   i_cfg_data
);

    logic [pul_pkg::CFG_W-1:0] r_perm_length;
    logic                      q_full;
    logic                      q_push;
    logic                      q_empty;
    logic                      q_pop;
    pul_pkg::t_job             front_job;
    pul_pkg::t_job             back_job;
    pul_pkg::t_elem            elems [pul_pkg::OUT_ELEMS];

    // config is always accepted; software must write it only while idle, the block does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_length <= pul_pkg::CFG_W'(9);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_perm_length <= i_cfg_data;
        end
    end

    // front: range check and rank - 1
    pul_front u_front (
        .i_push        (push),
        .i_rank        (i_rank),
        .i_perm_length (r_perm_length),
        .i_q_full      (q_full),
        .o_full        (full),
        .o_q_push      (q_push),
        .o_job         (front_job)
    );

    // decoupling queue
    pul_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (back_job),
        .o_empty (q_empty)
    );

    // back: factorial-base digits and value selection
    pul_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (back_job),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .o_elems      (elems),
        .o_rank_error (o_rank_error),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    assign o_elem_1 = elems[0];
    assign o_elem_2 = elems[1];
    assign o_elem_3 = elems[2];
    assign o_elem_4 = elems[3];
    assign o_elem_5 = elems[4];
    assign o_elem_6 = elems[5];
    assign o_elem_7 = elems[6];
    assign o_elem_8 = elems[7];
    assign o_elem_9 = elems[8];

endmodule

/* src/pul_fifo.sv */
// ----------------------------------------------------------------------------
// pul_fifo: job queue between front and back
// Small register queue of classified jobs.
// ----------------------------------------------------------------------------
module pul_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pul_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output pul_pkg::t_job o_data,
    output logic          o_empty
);

    pul_pkg::t_job                 r_mem [pul_pkg::Q_DEPTH];
    logic [pul_pkg::Q_AW-1:0]      r_wr_ptr;
    logic [pul_pkg::Q_AW-1:0]      r_rd_ptr;
    logic [pul_pkg::Q_AW:0]        r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (int'(r_count) == pul_pkg::Q_DEPTH);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == pul_pkg::Q_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == pul_pkg::Q_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/pul_front.sv */
// ----------------------------------------------------------------------------
// pul_front: rank intake and classification
// Checks the rank against n!, forms rank minus one and queues the job.
// ----------------------------------------------------------------------------
module pul_front (
    input  logic                        i_push,
    input  logic [pul_pkg::RANK_W-1:0]  i_rank,
    input  logic [pul_pkg::CFG_W-1:0]   i_perm_length,
    input  logic                        i_q_full,
    output logic                        o_full,
    output logic                        o_q_push,
    output pul_pkg::t_job               o_job
);

    logic [pul_pkg::LEN_W-1:0] len;
    logic                      bad;

    assign len = pul_pkg::eff_len(i_perm_length);
    assign bad = (i_rank == '0) ||
                 (pul_pkg::FACT_W'(i_rank) > pul_pkg::fact(len));

    assign o_full    = i_q_full;
    assign o_q_push  = i_push && !i_q_full;
    assign o_job.rest = i_rank - pul_pkg::RANK_W'(1);
    assign o_job.len  = len;
    assign o_job.err  = bad;

endmodule

/* src/pul_back.sv */
// ----------------------------------------------------------------------------
// pul_back: digit extraction and element selection
// Per position, subtracts the factorial until the remainder drops below it,
// then picks the digit-th smallest unused value. Holds one finished result.
// ----------------------------------------------------------------------------
module pul_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pul_pkg::t_job         i_job,
    input  logic                  i_q_empty,
    output logic                  o_q_pop,
    output pul_pkg::t_elem        o_elems [pul_pkg::OUT_ELEMS],
    output logic                  o_rank_error,
    output logic                  o_empty,
    input  logic                  i_pop
);

    pul_pkg::t_back_state         r_state;
    pul_pkg::t_back_state         n_state;
    logic [pul_pkg::RANK_W-1:0]   r_rest;
    logic [pul_pkg::RANK_W-1:0]   n_rest;
    logic [pul_pkg::LEN_W-1:0]    r_n;
    logic [pul_pkg::POS_W-1:0]    r_pos;
    logic [pul_pkg::POS_W-1:0]    n_pos;
    logic [pul_pkg::CNT_W-1:0]    r_digit;
    logic [pul_pkg::CNT_W-1:0]    n_digit;
    logic [pul_pkg::MAX_LEN-1:0]  r_used;
    logic [pul_pkg::MAX_LEN-1:0]  n_used;
    logic                         r_err;
    pul_pkg::t_elem               r_elems [pul_pkg::ARR_N];
    pul_pkg::t_elem               r_out_elems [pul_pkg::OUT_ELEMS];
    logic                         r_out_err;
    logic                         r_out_valid;

    logic [pul_pkg::FACT_W-1:0]   f;
    logic                         ge;
    logic                         last_pos;
    pul_pkg::t_elem               sel_val;
    logic [pul_pkg::MAX_LEN-1:0]  sel_bit;
    logic                         load_job;
    logic                         step_sub;
    logic                         step_pick;
    logic                         load_out;
    logic                         out_free;

    assign f        = pul_pkg::fact(pul_pkg::LEN_W'(int'(r_n) - 1 - int'(r_pos)));
    assign ge       = {{(pul_pkg::FACT_W - pul_pkg::RANK_W){1'b0}}, r_rest} >= f;
    assign last_pos = (int'(r_pos) == int'(r_n) - 1);
    assign out_free = !r_out_valid || i_pop;

    // digit-th smallest unused value among 1..n
    always_comb begin
        logic [pul_pkg::CNT_W-1:0] cnt;
        logic                      found;
        cnt     = '0;
        found   = 1'b0;
        sel_val = '0;
        sel_bit = '0;
        for (int v = 0; v < pul_pkg::MAX_LEN; v++) begin
            if (v < int'(r_n) && !r_used[v]) begin
                if (!found && cnt == r_digit) begin
                    sel_val    = pul_pkg::ELEM_W'(v + 1);
                    sel_bit[v] = 1'b1;
                    found      = 1'b1;
                end
                cnt = cnt + 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pul_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_job.err ? pul_pkg::BK_DONE : pul_pkg::BK_DIGIT;
                end
            end
            pul_pkg::BK_DIGIT: begin
                if (!ge && last_pos) begin
                    n_state = pul_pkg::BK_DONE;
                end
            end
            pul_pkg::BK_DONE: begin
                if (out_free) begin
                    n_state = pul_pkg::BK_IDLE;
                end
            end
            default: n_state = pul_pkg::BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        load_job  = 1'b0;
        step_sub  = 1'b0;
        step_pick = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            pul_pkg::BK_IDLE:  load_job  = !i_q_empty;
            pul_pkg::BK_DIGIT: begin
                step_sub  = ge;
                step_pick = !ge;
            end
            pul_pkg::BK_DONE:  load_out  = out_free;
            default: ;
        endcase
    end

    assign o_q_pop = load_job;

    always_comb begin
        n_rest  = r_rest;
        n_pos   = r_pos;
        n_digit = r_digit;
        n_used  = r_used;
        if (load_job) begin
            n_rest  = i_job.rest;
            n_pos   = '0;
            n_digit = '0;
            n_used  = '0;
        end else if (step_sub) begin
            n_rest  = r_rest - f[pul_pkg::RANK_W-1:0];
            n_digit = r_digit + 1'b1;
        end else if (step_pick) begin
            n_pos   = r_pos + 1'b1;
            n_digit = '0;
            n_used  = r_used | sel_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_pos   <= n_pos;
        r_digit <= n_digit;
        r_used  <= n_used;
        if (load_job) begin
            r_n   <= i_job.len;
            r_err <= i_job.err;
            for (int k = 0; k < pul_pkg::ARR_N; k++) begin
                r_elems[k] <= '0;
            end
        end else if (step_pick) begin
            r_elems[r_pos] <= sel_val;
        end
        if (load_out) begin
            for (int k = 0; k < pul_pkg::OUT_ELEMS; k++) begin
                r_out_elems[k] <= r_elems[k];
            end
            r_out_err <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pul_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_elems      = r_out_elems;
    assign o_rank_error = r_out_err;
    assign o_empty      = !r_out_valid;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pul_pkg::BK_DIGIT |-> int'(r_pos) < int'(r_n))
        else $error("position past length");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pul_pkg::BK_DIGIT |->
            int'(r_digit) <= int'(r_n) - 1 - int'(r_pos))
        else $error("digit exceeds unused count");

    a_all_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pul_pkg::BK_DONE && !r_err) |-> $countones(r_used) == int'(r_n))
        else $error("finished permutation does not use every value");

    a_pick_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_pick |-> $onehot(sel_bit))
        else $error("no unused value for digit");

endmodule
